/* rtl/pidc_pkg.sv */
// Shared types and constants for the dual-mode PID controller.
// Depends on nothing; used by pid_controller_dual_mode_top.
`timescale 1ns / 1ps
`default_nettype none

package pidc_pkg;

  // Q8.8 gains: fractional bits dropped after each product
  localparam int unsigned FRAC_BITS = 8;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned LIMIT_W    = 31;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MODE           = 3'd0,
    CFG_GAIN_P         = 3'd1,
    CFG_GAIN_I         = 3'd2,
    CFG_GAIN_D         = 3'd3,
    CFG_INTEGRAL_LIMIT = 3'd4
  } cfg_idx_e;

  typedef enum logic {
    MODE_POSITIONAL  = 1'b0,
    MODE_INCREMENTAL = 1'b1
  } mode_e;

endpackage : pidc_pkg

`default_nettype wire

/* rtl/pid_controller_dual_mode_top.sv */
// Dual-mode (positional / incremental) discrete PID controller, top level.
// Depends on pidc_pkg for register indexes, mode codes and fixed widths.
//
//   channel  | direction | handshake              | payload
//   ---------+-----------+------------------------+--------------------------------
//   cfg      | in        | cfg_valid_i/cfg_ready_o | cfg_index_i, cfg_data_i
//   in       | in        | in_valid_i/in_ready_o   | error_i
//   out      | out       | out_valid_o/out_ready_i | control_out_o, saturated_o
//
// One item per cycle sustained while the output is taken; an item is held in the input
// register, which feeds three gain multipliers and one adder tree into the result
// register; controller state updates in the same edge as the result register.
// Reset clears the gains, mode, limit, error history, integral and running output.
// A stalled output holds the result and the input register; in_ready_o drops only
// when both are full and the output is not taken. Configuration is always ready.
`timescale 1ns / 1ps
`default_nettype none

module pid_controller_dual_mode_top #(
  parameter int unsigned ERROR_WIDTH  = 16,
  parameter int unsigned GAIN_WIDTH   = 16,
  parameter int unsigned OUTPUT_WIDTH = 32
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,

  input  wire logic                                cfg_valid_i,
  output      logic                                cfg_ready_o,
  input  wire logic [pidc_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  wire logic [pidc_pkg::CFG_DATA_W-1:0]     cfg_data_i,

  input  wire logic                                in_valid_i,
  output      logic                                in_ready_o,
  input  wire logic signed [ERROR_WIDTH-1:0]       error_i,

  output      logic                                out_valid_o,
  input  wire logic                                out_ready_i,
  output      logic signed [OUTPUT_WIDTH-1:0]      control_out_o,
  output      logic                                saturated_o
);

  localparam int unsigned EW = ERROR_WIDTH;
  localparam int unsigned GW = GAIN_WIDTH;
  localparam int unsigned OW = OUTPUT_WIDTH;
  localparam int unsigned XW = (OW > EW + 2) ? OW : EW + 2;
  localparam int unsigned SUM_W = GW + XW + 3;
  localparam int unsigned IW = ((OW > EW) ? OW : EW) + 1;
  localparam int unsigned CW = ((OW > pidc_pkg::LIMIT_W) ? OW : pidc_pkg::LIMIT_W) + 1;

  localparam logic signed [SUM_W-1:0] SAT_MAX = {{(SUM_W-OW+1){1'b0}}, {(OW-1){1'b1}}};
  localparam logic signed [SUM_W-1:0] SAT_MIN = {{(SUM_W-OW+1){1'b1}}, {(OW-1){1'b0}}};

  // {flag, value}: clip to OW-bit signed range
  function automatic logic [OW:0] sat_ow(input logic signed [SUM_W-1:0] v);
    logic [OW:0] r;
    if (v > SAT_MAX) begin
      r = {1'b1, SAT_MAX[OW-1:0]};
    end else if (v < SAT_MIN) begin
      r = {1'b1, SAT_MIN[OW-1:0]};
    end else begin
      r = {1'b0, v[OW-1:0]};
    end
    return r;
  endfunction

  // configuration registers
  pidc_pkg::mode_e                mode_q;
  logic [GW-1:0]                  gain_p_q, gain_i_q, gain_d_q;
  logic [pidc_pkg::LIMIT_W-1:0]   limit_q;

  // controller state
  logic signed [EW-1:0]           e1_q, e2_q;
  logic signed [OW-1:0]           integral_q, integral_d;
  logic signed [OW-1:0]           running_q, running_d;

  // input and result registers
  logic                           in_valid_q;
  logic signed [EW-1:0]           e_q;
  logic                           out_valid_q;
  logic signed [OW-1:0]           result_q, result_d;
  logic                           sat_q, sat_d;

  logic                           out_free, load, in_accept;

  assign cfg_ready_o = 1'b1;
  assign out_free    = !out_valid_q || out_ready_i;
  assign load        = in_valid_q && out_free;
  assign in_ready_o  = !in_valid_q || out_free;
  assign in_accept   = in_valid_i && in_ready_o;

  // integral update with saturation and optional clamp
  logic signed [IW-1:0]    int_sum;
  logic [OW:0]             int_sat;
  logic signed [CW-1:0]    int_ext, lim_ext;
  logic signed [OW-1:0]    int_new;
  logic                    int_flag;

  assign int_sum = IW'(integral_q) + IW'(e_q);
  assign int_sat = sat_ow(SUM_W'(int_sum));
  assign int_ext = CW'($signed(int_sat[OW-1:0]));
  assign lim_ext = CW'($signed({1'b0, limit_q}));

  always_comb begin
    int_new  = $signed(int_sat[OW-1:0]);
    int_flag = int_sat[OW];
    if (limit_q != '0) begin
      if (int_ext > lim_ext) begin
        int_new  = OW'(lim_ext);
        int_flag = 1'b1;
      end else if (int_ext < -lim_ext) begin
        int_new  = OW'(-lim_ext);
        int_flag = 1'b1;
      end
    end
  end

  // gain operands, shared between modes
  logic signed [XW-1:0]    e_x, d1_x, d2_x;
  logic signed [XW-1:0]    x_p, x_i, x_d;
  logic signed [SUM_W-1:0] prod_p, prod_i, prod_d;
  logic signed [SUM_W-1:0] base, sum;
  logic [OW:0]             sum_sat;
  logic                    incr, gains_zero;

  assign incr       = (mode_q == pidc_pkg::MODE_INCREMENTAL);
  assign gains_zero = (gain_p_q == '0) && (gain_i_q == '0) && (gain_d_q == '0);

  assign e_x  = XW'(e_q);
  assign d1_x = e_x - XW'(e1_q);
  assign d2_x = e_x - (XW'(e1_q) <<< 1) + XW'(e2_q);

  assign x_p = incr ? d1_x : e_x;
  assign x_i = incr ? e_x  : XW'(int_new);
  assign x_d = incr ? d2_x : d1_x;

  assign prod_p = SUM_W'($signed({1'b0, gain_p_q})) * SUM_W'(x_p);
  assign prod_i = SUM_W'($signed({1'b0, gain_i_q})) * SUM_W'(x_i);
  assign prod_d = SUM_W'($signed({1'b0, gain_d_q})) * SUM_W'(x_d);

  assign base = incr ? SUM_W'(running_q) : '0;
  assign sum  = base + (prod_p >>> pidc_pkg::FRAC_BITS) + (prod_i >>> pidc_pkg::FRAC_BITS)
              + (prod_d >>> pidc_pkg::FRAC_BITS);
  assign sum_sat = sat_ow(sum);

  always_comb begin
    integral_d = integral_q;
    running_d  = running_q;
    result_d   = $signed(sum_sat[OW-1:0]);
    sat_d      = sum_sat[OW];
    if (!incr) begin
      integral_d = int_new;
      sat_d      = sum_sat[OW] | int_flag;
    end else if (gains_zero) begin
      running_d = '0;
      result_d  = '0;
      sat_d     = 1'b0;
    end else begin
      running_d = $signed(sum_sat[OW-1:0]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= pidc_pkg::MODE_POSITIONAL;
      gain_p_q    <= '0;
      gain_i_q    <= '0;
      gain_d_q    <= '0;
      limit_q     <= '0;
      e1_q        <= '0;
      e2_q        <= '0;
      integral_q  <= '0;
      running_q   <= '0;
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        case (pidc_pkg::cfg_idx_e'(cfg_index_i))
          pidc_pkg::CFG_MODE:           mode_q   <= pidc_pkg::mode_e'(cfg_data_i[0]);
          pidc_pkg::CFG_GAIN_P:         gain_p_q <= cfg_data_i[GW-1:0];
          pidc_pkg::CFG_GAIN_I:         gain_i_q <= cfg_data_i[GW-1:0];
          pidc_pkg::CFG_GAIN_D:         gain_d_q <= cfg_data_i[GW-1:0];
          pidc_pkg::CFG_INTEGRAL_LIMIT: limit_q  <= cfg_data_i[pidc_pkg::LIMIT_W-1:0];
          default: ;
        endcase
      end
      if (in_accept) begin
        in_valid_q <= 1'b1;
      end else if (load) begin
        in_valid_q <= 1'b0;
      end
      if (load) begin
        out_valid_q <= 1'b1;
        e1_q        <= e_q;
        e2_q        <= e1_q;
        integral_q  <= integral_d;
        running_q   <= running_d;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      e_q <= error_i;
    end
    if (load) begin
      result_q <= result_d;
      sat_q    <= sat_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign control_out_o = result_q;
  assign saturated_o   = sat_q;

`ifndef SYNTHESIS
  a_stall_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (in_valid_q && out_valid_q && !out_ready_i))
    else $error("input stalled while pipeline has room");

  a_zero_gain_incr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load && incr && gains_zero) |=> (control_out_o == '0 && !saturated_o && running_q == '0))
    else $error("incremental mode with zero gains did not clear output");

  a_integral_clamped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load && !incr && limit_q != '0) |=>
      (CW'(integral_q) <= $past(lim_ext) && CW'(integral_q) >= -$past(lim_ext)))
    else $error("integral outside clamp");

  a_running_held_positional: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load && !incr) |=> (running_q == $past(running_q)))
    else $error("running output changed in positional mode");

  a_history_shift: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |=> (e2_q == $past(e1_q) && e1_q == $past(e_q)))
    else $error("error history did not shift");
`endif

endmodule : pid_controller_dual_mode_top

`default_nettype wire

/* verif/pid_controller_dual_mode_top_tb.sv */
// Testbench for pid_controller_dual_mode_top: drives error items and register writes,
// predicts each control result in a scoreboard class and checks it field by field.
// Depends on pidc_pkg and the RTL of pid_controller_dual_mode_top.
`timescale 1ns / 1ps

module pid_controller_dual_mode_top_tb;

  localparam int unsigned CFG_IDX_W  = pidc_pkg::CFG_IDX_W;
  localparam int unsigned CFG_DATA_W = pidc_pkg::CFG_DATA_W;
  localparam int unsigned LIMIT_W    = pidc_pkg::LIMIT_W;
  localparam int unsigned FRAC_BITS  = pidc_pkg::FRAC_BITS;

  localparam int ERR_W = 16;
  localparam int OUT_W = 32;
  localparam longint OUT_MAX = 64'sd2147483647;
  localparam longint OUT_MIN = -64'sd2147483648;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_TOP = CFG_IDX_W'((1 << CFG_IDX_W) - 1);
  localparam int WINDUP_ITEMS = 40;
  localparam int RANDOM_PHASES = 12;
  localparam int PHASE_ITEMS = 135;

  typedef struct packed {
    logic signed [OUT_W-1:0] control;
    logic                    sat;
  } pid_result_t;

  class pid_scoreboard;
    pidc_pkg::mode_e   mode;
    logic [15:0]       gain_p;
    logic [15:0]       gain_i;
    logic [15:0]       gain_d;
    logic [LIMIT_W-1:0] int_limit;
    longint            prev_err;
    longint            prev2_err;
    longint            integral;
    longint            running;
    pid_result_t       result_q[$];
    int                fail_count;

    function new();
      mode = pidc_pkg::MODE_POSITIONAL;
      gain_p = '0;
      gain_i = '0;
      gain_d = '0;
      int_limit = '0;
      prev_err = 0;
      prev2_err = 0;
      integral = 0;
      running = 0;
      fail_count = 0;
    endfunction

    task report(string msg);
      if (fail_count < 50) $display("mismatch @%0t: %s", $realtime, msg);
      fail_count++;
    endtask

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        pidc_pkg::CFG_MODE:           mode = pidc_pkg::mode_e'(data[0]);
        pidc_pkg::CFG_GAIN_P:         gain_p = data[15:0];
        pidc_pkg::CFG_GAIN_I:         gain_i = data[15:0];
        pidc_pkg::CFG_GAIN_D:         gain_d = data[15:0];
        pidc_pkg::CFG_INTEGRAL_LIMIT: int_limit = data[LIMIT_W-1:0];
        default: ;
      endcase
    endfunction

    function longint clip(longint v, inout bit hit);
      if (v > OUT_MAX) begin
        hit = 1'b1;
        return OUT_MAX;
      end
      if (v < OUT_MIN) begin
        hit = 1'b1;
        return OUT_MIN;
      end
      return v;
    endfunction

    // floor(g * x / 256) for an unsigned Q8.8 gain
    function longint scaled(logic [15:0] g, longint x);
      longint g64;
      g64 = longint'({48'd0, g});
      return (g64 * x) >>> FRAC_BITS;
    endfunction

    function void note_error(logic signed [ERR_W-1:0] e);
      longint      ev;
      longint      lim;
      longint      sum;
      longint      outv;
      bit          hit;
      pid_result_t r;
      ev = longint'(e);
      hit = 1'b0;
      if (mode == pidc_pkg::MODE_POSITIONAL) begin
        integral = clip(integral + ev, hit);
        lim = longint'({33'd0, int_limit});
        if (lim != 0) begin
          if (integral > lim) begin
            integral = lim;
            hit = 1'b1;
          end else if (integral < -lim) begin
            integral = -lim;
            hit = 1'b1;
          end
        end
        sum = scaled(gain_p, ev) + scaled(gain_i, integral) + scaled(gain_d, ev - prev_err);
        outv = clip(sum, hit);
      end else if (gain_p == 0 && gain_i == 0 && gain_d == 0) begin
        running = 0;
        outv = 0;
      end else begin
        sum = running + scaled(gain_p, ev - prev_err) + scaled(gain_i, ev)
            + scaled(gain_d, ev - 2 * prev_err + prev2_err);
        running = clip(sum, hit);
        outv = running;
      end
      prev2_err = prev_err;
      prev_err = ev;
      r.control = outv[OUT_W-1:0];
      r.sat = hit;
      result_q.push_back(r);
    endfunction

    task check_result(logic signed [OUT_W-1:0] control, logic sat);
      pid_result_t r;
      if (result_q.size() == 0) begin
        report($sformatf("result with none pending: control=%0d sat=%0b", control, sat));
      end else begin
        r = result_q.pop_front();
        if (control !== r.control)
          report($sformatf("control_out got %0d want %0d", control, r.control));
        if (sat !== r.sat)
          report($sformatf("saturated got %0b want %0b (control %0d)", sat, r.sat, r.control));
      end
    endtask
  endclass

  logic                          clk_i;
  logic                          rst_ni;
  logic                          cfg_valid_i;
  logic                          cfg_ready_o;
  logic [CFG_IDX_W-1:0]          cfg_index_i;
  logic [CFG_DATA_W-1:0]         cfg_data_i;
  logic                          in_valid_i;
  logic                          in_ready_o;
  logic signed [ERR_W-1:0]       error_i;
  logic                          out_valid_o;
  logic                          out_ready_i;
  logic signed [OUT_W-1:0]       control_out_o;
  logic                          saturated_o;

  bit in_idle_on;
  bit out_stall_on;
  pid_scoreboard sb;

  pid_controller_dual_mode_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .error_i       (error_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .control_out_o (control_out_o),
    .saturated_o   (saturated_o)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) sb.check_result(control_out_o, saturated_o);
  end

  initial begin : out_ready_driver
    int stall_left;
    stall_left = 0;
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (stall_left == 0 && out_stall_on && $urandom_range(0, 5) == 0)
        stall_left = $urandom_range(1, 9);
      if (stall_left > 0) begin
        out_ready_i = 1'b0;
        stall_left--;
      end else begin
        out_ready_i = 1'b1;
      end
    end
  end

  initial begin : watchdog
    #20_000_000;
    $display("== FAIL ==");
    $finish;
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i = data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    sb.write_reg(idx, data);
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  task automatic send_error(logic signed [ERR_W-1:0] e);
    if (in_idle_on && $urandom_range(0, 3) == 0) begin
      in_valid_i = 1'b0;
      repeat ($urandom_range(1, 9)) @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    error_i = e;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    sb.note_error(e);
    @(negedge clk_i);
  endtask

  // drop valid and wait until every pending result has come out
  task automatic settle();
    in_valid_i = 1'b0;
    while (sb.result_q.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic load_config(pidc_pkg::mode_e m, logic [15:0] p, logic [15:0] i,
                             logic [15:0] d, logic [LIMIT_W-1:0] lim);
    write_reg(pidc_pkg::CFG_MODE, CFG_DATA_W'(m));
    write_reg(pidc_pkg::CFG_GAIN_P, CFG_DATA_W'(p));
    write_reg(pidc_pkg::CFG_GAIN_I, CFG_DATA_W'(i));
    write_reg(pidc_pkg::CFG_GAIN_D, CFG_DATA_W'(d));
    write_reg(pidc_pkg::CFG_INTEGRAL_LIMIT, CFG_DATA_W'(lim));
  endtask

  function automatic logic [CFG_DATA_W-1:0] rand_gain();
    logic [15:0] g;
    case ($urandom_range(0, 5))
      0: g = 16'h0000;
      1: g = 16'hFFFF;
      2: g = 16'h0100;
      3: g = 16'($urandom_range(0, 16'h03FF));
      default: g = 16'($urandom());
    endcase
    return {16'($urandom()), g};
  endfunction

  function automatic logic [CFG_DATA_W-1:0] rand_limit();
    logic [LIMIT_W-1:0] lim;
    case ($urandom_range(0, 5))
      0: lim = '0;
      1: lim = LIMIT_W'(1);
      2: lim = '1;
      3: lim = LIMIT_W'($urandom_range(1, 100000));
      default: lim = LIMIT_W'($urandom());
    endcase
    return {1'($urandom()), lim};
  endfunction

  function automatic logic signed [ERR_W-1:0] rand_error();
    logic signed [ERR_W-1:0] v;
    case ($urandom_range(0, 7))
      0: begin
        case ($urandom_range(0, 4))
          0: v = 16'sh7FFF;
          1: v = 16'sh8000;
          2: v = '0;
          3: v = 16'sd1;
          default: v = -16'sd1;
        endcase
      end
      1, 2, 3: v = ERR_W'(int'($urandom_range(0, 400)) - 200);
      default: v = ERR_W'($urandom());
    endcase
    return v;
  endfunction

  initial begin : stimulus
    sb = new();
    in_idle_on = 1'b0;
    out_stall_on = 1'b0;
    rst_ni = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = '0;
    cfg_data_i = '0;
    in_valid_i = 1'b0;
    error_i = '0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // reset config: positional, all gains zero
    send_error(16'sd0);
    send_error(16'sh7FFF);
    send_error(16'sh8000);
    settle();

    // incremental with all gains zero, junk in the upper data bits
    write_reg(pidc_pkg::CFG_MODE, 32'hDEAD_BEE1);
    write_reg(pidc_pkg::CFG_GAIN_P, 32'hFFFF_0000);
    write_reg(pidc_pkg::CFG_GAIN_I, 32'h1234_0000);
    write_reg(pidc_pkg::CFG_GAIN_D, 32'h8000_0000);
    write_reg(CFG_IDX_TOP, 32'hFFFF_FFFF);
    send_error(16'sd100);
    send_error(-16'sd5);
    settle();

    load_config(pidc_pkg::MODE_POSITIONAL, 16'h0100, 16'h0010, 16'h0080, LIMIT_W'(1000));
    send_error(16'sh7FFF);
    send_error(16'sh7FFF);
    send_error(16'sh8000);
    send_error(16'sh8000);
    send_error(16'sh8000);
    send_error(16'sd1);
    send_error(-16'sd1);
    send_error(16'sd0);
    settle();

    load_config(pidc_pkg::MODE_INCREMENTAL, 16'hFFFF, 16'hFFFF, 16'hFFFF, '0);
    send_error(16'sh7FFF);
    send_error(16'sh8000);
    send_error(16'sh7FFF);
    send_error(16'sh8000);
    send_error(16'sd1);
    send_error(-16'sd1);
    settle();

    load_config(pidc_pkg::MODE_POSITIONAL, 16'hFFFF, 16'hFFFF, 16'hFFFF, '1);
    send_error(16'sh7FFF);
    send_error(16'sh8000);
    send_error(-16'sd1);
    send_error(16'sd0);
    settle();

    // wind the integral into the clamp on both sides, then back the other way
    load_config(pidc_pkg::MODE_POSITIONAL, 16'h0000, 16'h0001, 16'h0000, LIMIT_W'(300000));
    repeat (WINDUP_ITEMS) send_error(16'sh7FFF);
    repeat (2 * WINDUP_ITEMS) send_error(16'sh8000);
    repeat (WINDUP_ITEMS) send_error(16'sh7FFF);
    settle();

    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      in_idle_on = (ph < RANDOM_PHASES - 2) && ($urandom_range(0, 3) != 0);
      out_stall_on = (ph < RANDOM_PHASES - 2) && ($urandom_range(0, 3) != 0);
      write_reg(pidc_pkg::CFG_MODE, ($urandom() & ~32'h1) | CFG_DATA_W'($urandom_range(0, 1)));
      write_reg(pidc_pkg::CFG_GAIN_P, rand_gain());
      write_reg(pidc_pkg::CFG_GAIN_I, rand_gain());
      write_reg(pidc_pkg::CFG_GAIN_D, rand_gain());
      write_reg(pidc_pkg::CFG_INTEGRAL_LIMIT, rand_limit());
      if ($urandom_range(0, 2) == 0)
        write_reg(CFG_IDX_W'($urandom_range(pidc_pkg::CFG_INTEGRAL_LIMIT + 1, CFG_IDX_TOP)),
                  $urandom());
      repeat (PHASE_ITEMS) send_error(rand_error());
      settle();
    end

    if (sb.fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
